// File: hdl/fpfa_pkg.sv
`timescale 1ns / 1ps

package fpfa_pkg;

    localparam int MAX_HOLES = 16;
    localparam int SIZE_BITS = 16;
    localparam int IDX_BITS = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;

    localparam int HOLE_INDEX_BITS = 4;
    localparam int REQ_SIZE_BITS = 16;
    localparam int FIT_MODE_BITS = 2;
    localparam int HOLE_COUNT_BITS = 5;
    localparam int BLOCK_NUM_BITS = 5;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_FIT_MODE = 3'd0;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_HOLE_COUNT = 3'd4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [FIT_MODE_BITS-1:0] MODE_FIRST = 2'd0;
    localparam logic [FIT_MODE_BITS-1:0] MODE_BEST = 2'd1;
    localparam logic [FIT_MODE_BITS-1:0] MODE_WORST = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                       valid;
        logic                       found;
        logic [SIZE_BITS-1:0]       want;
        logic [IDX_BITS-1:0]        best_idx;
        logic [SIZE_BITS-1:0]       best_size;
    } token_t;

    typedef struct packed {
        logic                       we;
        logic [HOLE_INDEX_BITS-1:0] idx;
        logic [SIZE_BITS-1:0]       size;
    } load_bus_t;

    typedef struct packed {
        logic                       valid;
        logic [IDX_BITS-1:0]        idx;
    } mark_bus_t;

endpackage

// File: hdl/fpfa_cell.sv
`timescale 1ns / 1ps

module fpfa_cell (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [fpfa_pkg::IDX_BITS-1:0]          cell_index,
    input  logic [fpfa_pkg::FIT_MODE_BITS-1:0]     fit_mode,
    input  logic [fpfa_pkg::HOLE_COUNT_BITS-1:0]   hole_count,
    input  fpfa_pkg::load_bus_t                    load_bus,
    input  fpfa_pkg::mark_bus_t                    mark_bus,
    input  fpfa_pkg::token_t                       tok_in,
    output fpfa_pkg::token_t                       tok_out
);
    import fpfa_pkg::*;

    logic [SIZE_BITS-1:0] size_reg;
    logic                 used_reg;
    logic                 used_next;
    token_t               tok_reg;
    token_t               tok_next;
    logic                 eligible;
    logic                 take;

    always_comb
    begin
        eligible = (int'(cell_index) < int'(hole_count)) && !used_reg
                   && (size_reg >= tok_in.want);
        case (fit_mode)
            MODE_BEST:  take = eligible && (!tok_in.found || size_reg < tok_in.best_size);
            MODE_WORST: take = eligible && (!tok_in.found || size_reg > tok_in.best_size);
            default:    take = eligible && !tok_in.found;
        endcase
        tok_next = tok_in;
        if (take)
        begin
            tok_next.found = 1'b1;
            tok_next.best_idx = cell_index;
            tok_next.best_size = size_reg;
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (load_bus.we && int'(load_bus.idx) == int'(cell_index))
        begin
            used_next = 1'b0;
        end
        else if (mark_bus.valid && mark_bus.idx == cell_index)
        begin
            used_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tok_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_bus.we && int'(load_bus.idx) == int'(cell_index))
        begin
            size_reg <= load_bus.size;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: hdl/fpfa_chain.sv
`timescale 1ns / 1ps

module fpfa_chain (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [fpfa_pkg::FIT_MODE_BITS-1:0]     fit_mode,
    input  logic [fpfa_pkg::HOLE_COUNT_BITS-1:0]   hole_count,
    input  fpfa_pkg::load_bus_t                    load_bus,
    input  fpfa_pkg::mark_bus_t                    mark_bus,
    input  fpfa_pkg::token_t                       tok_in,
    output fpfa_pkg::token_t                       tok_out
);
    import fpfa_pkg::*;

    token_t tok_link [MAX_HOLES+1];

    assign tok_link[0] = tok_in;

    for (genvar i = 0; i < MAX_HOLES; i++)
    begin : g_cell
        fpfa_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (IDX_BITS'(i)),
            .fit_mode   (fit_mode),
            .hole_count (hole_count),
            .load_bus   (load_bus),
            .mark_bus   (mark_bus),
            .tok_in     (tok_link[i]),
            .tok_out    (tok_link[i+1])
        );
    end

    assign tok_out = tok_link[MAX_HOLES];

endmodule

// File: hdl/fixed_partition_fit_allocator_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_axis    in         s_tvalid/s_tready  tuser opcode, tdata hole_index and size
// m_axis    out        m_tvalid/m_tready  tuser granted, tdata block_number
// apb       in         psel/penable       fit_mode at 0x0, hole_count at 0x4
//
// A load produces no result transfer.
// A request travels through one registered cell per hole, and the next input is taken
// only after its result has been moved into the output register.
// A request waits in ST_DONE while the output register holds an unaccepted result.
// Reset clears every used mark, the config registers and all handshake state.
// A result waits in the output register while the next input is taken.
module fixed_partition_fit_allocator_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [23:0]                            s_tdata,   // hole_index, size
    input  logic                                   s_tuser,   // opcode
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [7:0]                             m_tdata,   // block_number
    output logic                                   m_tuser,   // granted
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [fpfa_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [fpfa_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [fpfa_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready
);
    import fpfa_pkg::*;

    state_t                     state_reg;
    state_t                     state_next;
    logic [FIT_MODE_BITS-1:0]   fit_mode_reg;
    logic [HOLE_COUNT_BITS-1:0] hole_count_reg;
    token_t                     res_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       out_granted_reg;
    logic [BLOCK_NUM_BITS-1:0]  out_block_reg;

    logic                       s_accept;
    logic                       deliver;
    logic                       cfg_write;
    logic [HOLE_INDEX_BITS-1:0] in_index;
    logic [REQ_SIZE_BITS-1:0]   in_size;
    load_bus_t                  load_bus;
    mark_bus_t                  mark_bus;
    token_t                     tok_in;
    token_t                     tok_out;

    assign in_index = s_tdata[HOLE_INDEX_BITS-1:0];
    assign in_size = s_tdata[HOLE_INDEX_BITS +: REQ_SIZE_BITS];
    assign s_accept = s_tvalid && s_tready;
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr)
            ADDR_FIT_MODE:   prdata = APB_DATA_BITS'(fit_mode_reg);
            ADDR_HOLE_COUNT: prdata = APB_DATA_BITS'(hole_count_reg);
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept && s_tuser == OP_REQUEST)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tok_out.valid)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        deliver = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

        load_bus.we = s_accept && s_tuser == OP_LOAD;
        load_bus.idx = in_index;
        load_bus.size = SIZE_BITS'(in_size);

        tok_in.valid = s_accept && s_tuser == OP_REQUEST;
        tok_in.found = 1'b0;
        tok_in.want = SIZE_BITS'(in_size);
        tok_in.best_idx = '0;
        tok_in.best_size = '0;

        mark_bus.valid = deliver && res_reg.found;
        mark_bus.idx = res_reg.best_idx;

        if (deliver)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    fpfa_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .fit_mode   (fit_mode_reg),
        .hole_count (hole_count_reg),
        .load_bus   (load_bus),
        .mark_bus   (mark_bus),
        .tok_in     (tok_in),
        .tok_out    (tok_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fit_mode_reg <= '0;
            hole_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && paddr == ADDR_FIT_MODE)
            begin
                fit_mode_reg <= pwdata[FIT_MODE_BITS-1:0];
            end
            if (cfg_write && paddr == ADDR_HOLE_COUNT)
            begin
                hole_count_reg <= pwdata[HOLE_COUNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN && tok_out.valid)
        begin
            res_reg <= tok_out;
        end
        if (deliver)
        begin
            out_granted_reg <= res_reg.found;
            out_block_reg <= res_reg.found
                ? BLOCK_NUM_BITS'(32'(res_reg.best_idx) + 32'd1)
                : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser = out_granted_reg;
    assign m_tdata = {{(8 - BLOCK_NUM_BITS){1'b0}}, out_block_reg};

endmodule

// File: verif/tb_fixed_partition_fit_allocator_unit.sv
`timescale 1ns / 1ps

module tb_fixed_partition_fit_allocator_unit;
    import fpfa_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 30;
    localparam int EPISODES = 40;
    localparam int ITEMS_PER_EPISODE = 40;
    localparam logic [FIT_MODE_BITS-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic                      granted;
        logic [BLOCK_NUM_BITS-1:0] number;
    } grant_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_ITEM,
        ROW_KNOWN
    } row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [APB_ADDR_BITS-1:0]   addr;
        logic [APB_DATA_BITS-1:0]   value;
        logic                       op;
        logic [HOLE_INDEX_BITS-1:0] idx;
        logic [REQ_SIZE_BITS-1:0]   size;
        logic                       granted;
        logic [BLOCK_NUM_BITS-1:0]  number;
    } plan_row_t;

    localparam int PLAN_ROWS = 25;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{ROW_KNOWN, ADDR_FIT_MODE, 32'd0, OP_REQUEST, 4'd0, 16'd0, 1'b0, 5'd0},
        '{ROW_ITEM, ADDR_FIT_MODE, 32'd0, OP_LOAD, 4'd0, 16'd100, 1'b0, 5'd0},
        '{ROW_ITEM, ADDR_FIT_MODE, 32'd0, OP_LOAD, 4'd1, 16'd50, 1'b0, 5'd0},
        '{ROW_ITEM, ADDR_FIT_MODE, 32'd0, OP_LOAD, 4'd2, 16'd200, 1'b0, 5'd0},
        '{ROW_ITEM, ADDR_FIT_MODE, 32'd0, OP_LOAD, 4'd3, 16'd50, 1'b0, 5'd0},
        '{ROW_ITEM, ADDR_FIT_MODE, 32'd0, OP_LOAD, 4'd15, 16'hFFFF, 1'b0, 5'd0},
        '{ROW_CFG, ADDR_HOLE_COUNT, 32'd4, OP_LOAD, 4'd0, 16'd0, 1'b0, 5'd0},
        '{ROW_CFG, ADDR_FIT_MODE, {30'd0, MODE_FIRST}, OP_LOAD, 4'd0, 16'd0, 1'b0, 5'd0},
        '{ROW_ITEM, ADDR_FIT_MODE, 32'd0, OP_REQUEST, 4'd0, 16'd60, 1'b0, 5'd0},
        '{ROW_ITEM, ADDR_FIT_MODE, 32'd0, OP_REQUEST, 4'd0, 16'd0, 1'b0, 5'd0},
        '{ROW_KNOWN, ADDR_FIT_MODE, 32'd0, OP_REQUEST, 4'd0, 16'hFFFF, 1'b0, 5'd0},
        '{ROW_CFG, ADDR_FIT_MODE, {30'd0, MODE_BEST}, OP_LOAD, 4'd0, 16'd0, 1'b0, 5'd0},
        '{ROW_ITEM, ADDR_FIT_MODE, 32'd0, OP_LOAD, 4'd0, 16'd100, 1'b0, 5'd0},
        '{ROW_ITEM, ADDR_FIT_MODE, 32'd0, OP_LOAD, 4'd1, 16'd50, 1'b0, 5'd0},
        '{ROW_ITEM, ADDR_FIT_MODE, 32'd0, OP_REQUEST, 4'd0, 16'd50, 1'b0, 5'd0},
        '{ROW_ITEM, ADDR_FIT_MODE, 32'd0, OP_REQUEST, 4'd0, 16'd50, 1'b0, 5'd0},
        '{ROW_ITEM, ADDR_FIT_MODE, 32'd0, OP_REQUEST, 4'd0, 16'd50, 1'b0, 5'd0},
        '{ROW_CFG, ADDR_FIT_MODE, {30'd0, MODE_WORST}, OP_LOAD, 4'd0, 16'd0, 1'b0, 5'd0},
        '{ROW_ITEM, ADDR_FIT_MODE, 32'd0, OP_LOAD, 4'd0, 16'd100, 1'b0, 5'd0},
        '{ROW_ITEM, ADDR_FIT_MODE, 32'd0, OP_LOAD, 4'd1, 16'd50, 1'b0, 5'd0},
        '{ROW_ITEM, ADDR_FIT_MODE, 32'd0, OP_LOAD, 4'd3, 16'd50, 1'b0, 5'd0},
        '{ROW_ITEM, ADDR_FIT_MODE, 32'd0, OP_REQUEST, 4'd0, 16'd1, 1'b0, 5'd0},
        '{ROW_ITEM, ADDR_FIT_MODE, 32'd0, OP_REQUEST, 4'd0, 16'd1, 1'b0, 5'd0},
        '{ROW_CFG, ADDR_FIT_MODE, {30'd0, MODE_SPARE}, OP_LOAD, 4'd0, 16'd0, 1'b0, 5'd0},
        '{ROW_ITEM, ADDR_FIT_MODE, 32'd0, OP_REQUEST, 4'd0, 16'd0, 1'b0, 5'd0}
    };

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [23:0]                s_tdata = '0;   // hole_index [3:0], size [19:4]
    logic                       s_tuser = 1'b0; // opcode
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [7:0]                 m_tdata;        // block_number [4:0]
    logic                       m_tuser;        // granted
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0]   paddr = '0;
    logic [APB_DATA_BITS-1:0]   pwdata = '0;
    logic [APB_DATA_BITS-1:0]   prdata;
    logic                       pready;

    logic [SIZE_BITS-1:0]       shadow_size [MAX_HOLES];
    logic                       hole_taken [MAX_HOLES];
    logic [FIT_MODE_BITS-1:0]   fit_sel;
    logic [HOLE_COUNT_BITS-1:0] hole_limit;
    grant_t                     grant_queue [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycle_count = 0;
    int error_count = 0;
    int load_count = 0;
    int request_count = 0;
    int grant_count = 0;
    int write_count = 0;

    fixed_partition_fit_allocator_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, grant_queue.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Applies the fit policy to the shadow hole table and claims the chosen hole.
    function automatic grant_t serve_request(input logic [SIZE_BITS-1:0] want);
        int     span;
        int     pick;
        logic [SIZE_BITS-1:0] pick_size;
        grant_t res;
        span = (hole_limit > MAX_HOLES) ? MAX_HOLES : int'(hole_limit);
        pick = -1;
        pick_size = '0;
        for (int i = 0; i < span; i++)
        begin
            if (!hole_taken[i] && shadow_size[i] >= want)
            begin
                if (pick < 0)
                begin
                    pick = i;
                    pick_size = shadow_size[i];
                    if (fit_sel != MODE_BEST && fit_sel != MODE_WORST)
                        break;
                end
                else if (fit_sel == MODE_BEST && shadow_size[i] < pick_size)
                begin
                    pick = i;
                    pick_size = shadow_size[i];
                end
                else if (fit_sel == MODE_WORST && shadow_size[i] > pick_size)
                begin
                    pick = i;
                    pick_size = shadow_size[i];
                end
            end
        end
        if (pick < 0)
        begin
            res.granted = 1'b0;
            res.number = '0;
        end
        else
        begin
            hole_taken[pick] = 1'b1;
            res.granted = 1'b1;
            res.number = BLOCK_NUM_BITS'(pick + 1);
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (grant_queue.size() == 0)
                report_mismatch($sformatf("unexpected result granted=%0b tdata=0x%02h",
                                          m_tuser, m_tdata));
            else
            begin
                want = grant_queue.pop_front();
                if (m_tuser !== want.granted)
                    report_mismatch($sformatf("granted %0b, expected %0b",
                                              m_tuser, want.granted));
                if (m_tdata !== {3'b000, want.number})
                    report_mismatch($sformatf("block number tdata 0x%02h, expected %0d",
                                              m_tdata, want.number));
                if (want.granted)
                    grant_count++;
            end
        end
    end

    task automatic send_item(input logic op, input logic [HOLE_INDEX_BITS-1:0] idx,
                             input logic [REQ_SIZE_BITS-1:0] sz, input bit known,
                             input grant_t known_res);
        grant_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'b0000, sz, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == OP_LOAD)
        begin
            shadow_size[idx] = sz;
            hole_taken[idx] = 1'b0;
            load_count++;
        end
        else
        begin
            predicted = serve_request(sz);
            grant_queue.push_back(known ? known_res : predicted);
            request_count++;
        end
    endtask

    // Stops the sender and lets the block go quiet before a register write.
    task automatic drain;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (grant_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_BITS-1:0] addr,
                             input logic [APB_DATA_BITS-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == ADDR_FIT_MODE)
            fit_sel = data[FIT_MODE_BITS-1:0];
        else if (addr == ADDR_HOLE_COUNT)
            hole_limit = data[HOLE_COUNT_BITS-1:0];
        write_count++;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Mostly coarse sizes so that holes tie and requests land exactly on a hole size.
    function automatic logic [REQ_SIZE_BITS-1:0] random_size;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return REQ_SIZE_BITS'($urandom_range(0, 8) * 1024);
        else if (roll < 75)
            return REQ_SIZE_BITS'($urandom_range(0, 8192));
        else if (roll < 85)
        begin
            case ($urandom_range(0, 3))
                0: return 16'h0000;
                1: return 16'h0001;
                2: return 16'hFFFE;
                default: return 16'hFFFF;
            endcase
        end
        else
            return REQ_SIZE_BITS'($urandom());
    endfunction

    initial
    begin
        grant_t typed_res;
        logic [HOLE_COUNT_BITS-1:0] count_pick;
        int extreme_counts [4];
        extreme_counts = '{16, 31, 0, 1};
        fit_sel = MODE_FIRST;
        hole_limit = '0;
        for (int i = 0; i < MAX_HOLES; i++)
        begin
            shadow_size[i] = '0;
            hole_taken[i] = 1'b0;
        end
        tx_idle_pct = 30;
        rx_idle_pct = 72;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (PLAN[r].kind == ROW_CFG)
            begin
                drain();
                apb_write(PLAN[r].addr, PLAN[r].value);
            end
            else
            begin
                typed_res.granted = PLAN[r].granted;
                typed_res.number = PLAN[r].number;
                send_item(PLAN[r].op, PLAN[r].idx, PLAN[r].size,
                          PLAN[r].kind == ROW_KNOWN, typed_res);
            end
        end

        // Every hole gets a size before the count can reach past the first four.
        for (int i = 0; i < MAX_HOLES; i++)
            send_item(OP_LOAD, HOLE_INDEX_BITS'(i), random_size(), 1'b0, typed_res);

        for (int ep = 0; ep < EPISODES; ep++)
        begin
            if (ep < EPISODES / 3)
            begin
                tx_idle_pct = 30;
                rx_idle_pct = 72;
            end
            else if (ep < 2 * EPISODES / 3)
            begin
                tx_idle_pct = 72;
                rx_idle_pct = 30;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (ep < 4)
                count_pick = HOLE_COUNT_BITS'(extreme_counts[ep]);
            else
                count_pick = HOLE_COUNT_BITS'($urandom_range(1, 16));
            drain();
            apb_write(ADDR_FIT_MODE, APB_DATA_BITS'(ep % 4));
            apb_write(ADDR_HOLE_COUNT, APB_DATA_BITS'(count_pick));
            for (int k = 0; k < ITEMS_PER_EPISODE; k++)
            begin
                if ($urandom_range(0, 99) < 35)
                    send_item(OP_LOAD, HOLE_INDEX_BITS'($urandom_range(0, 15)),
                              random_size(), 1'b0, typed_res);
                else
                    send_item(OP_REQUEST, HOLE_INDEX_BITS'($urandom_range(0, 15)),
                              random_size(), 1'b0, typed_res);
            end
        end

        drain();
        $display("Run covered %0d hole loads and %0d requests, %0d of them granted,",
                 load_count, request_count, grant_count);
        $display("over %0d register writes spanning all fit modes and hole counts 0 to 31.",
                 write_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
